// ----- rtl/core/dnlc_pkg.sv -----
// ----------------------------------------------------------------------------
// dnlc_pkg: shared types and constants of the day/night lamp controller
// Holds the mode, item kind, event and register index codes and the widths.
// ----------------------------------------------------------------------------
package dnlc_pkg;

	// Bits of the light reading and threshold that take part in the compare.
	localparam int LIGHT_BITS = 10;

	localparam int LEVEL_W   = 10;
	localparam int HOLD_W    = 16;
	localparam int OFF_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	// Only the low bits present in both operands can take part in the compare.
	localparam int CMP_BITS = (LIGHT_BITS < LEVEL_W) ? LIGHT_BITS : LEVEL_W;

	localparam logic [LEVEL_W-1:0] RST_LIGHT_THRESHOLD   = 10'd250;
	localparam logic [HOLD_W-1:0]  RST_LIGHT_HOLD_TICKS  = 16'd6000;
	localparam logic [HOLD_W-1:0]  RST_BUTTON_HOLD_TICKS = 16'd25;
	localparam logic [OFF_W-1:0]   RST_OFF_TIMEOUT_TICKS = 24'd1440000;

	typedef enum logic [1:0] {
		MODE_DAY_OFF   = 2'd0,
		MODE_DAY_ON    = 2'd1,
		MODE_NIGHT_OFF = 2'd2,
		MODE_NIGHT_ON  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_BUTTON = 2'd1,
		FUNC_SHAKE  = 2'd2,
		FUNC_LIGHT  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_BUTTON  = 3'd1,
		EV_SHAKE   = 3'd2,
		EV_BRIGHT  = 3'd3,
		EV_DARK    = 3'd4,
		EV_TIMEOUT = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_THRESHOLD   = 2'd0,
		REG_LIGHT_HOLD_TICKS  = 2'd1,
		REG_BUTTON_HOLD_TICKS = 2'd2,
		REG_OFF_TIMEOUT_TICKS = 2'd3
	} reg_idx_t;

endpackage

// ----- rtl/core/day_night_lamp_controller_unit.sv -----
// ----------------------------------------------------------------------------
// day_night_lamp_controller_unit: four-state day/night lamp controller
// A word passes the input register, then the result register; one word per cycle unless out_stall holds it.
// The input register and the result register each advance by one whole word.
// Reset puts the lamp in day-off, clears the hold-offs, arms the off timeout.
// ----------------------------------------------------------------------------
module day_night_lamp_controller_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [dnlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dnlc_pkg::CFG_DAT_W-1:0]    cfg_data,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [dnlc_pkg::LEVEL_W-1:0]      light_level,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        lamp_mode,
	output logic                              leds_on,
	output logic                              mode_changed,
	output logic                              timeout_fired
);

	// Configuration registers.
	logic [dnlc_pkg::LEVEL_W-1:0] light_threshold_q;
	logic [dnlc_pkg::HOLD_W-1:0]  light_hold_ticks_q;
	logic [dnlc_pkg::HOLD_W-1:0]  button_hold_ticks_q;
	logic [dnlc_pkg::OFF_W-1:0]   off_timeout_ticks_q;

	// Controller state.
	dnlc_pkg::mode_t              mode_q;
	logic [dnlc_pkg::HOLD_W-1:0]  light_hold_left_q;
	logic [dnlc_pkg::HOLD_W-1:0]  button_hold_left_q;
	logic [dnlc_pkg::OFF_W-1:0]   off_count_left_q;
	logic                         off_armed_q;

	// Input register stage.
	logic                         valid_s1;
	dnlc_pkg::func_t              func_s1;
	logic [dnlc_pkg::LEVEL_W-1:0] level_s1;

	// Result register.
	logic                         out_valid_q;
	dnlc_pkg::mode_t              lamp_mode_q;
	logic                         mode_changed_q;
	logic                         timeout_fired_q;

	// Step logic.
	logic                         adv_s1;
	logic                         take_in;
	dnlc_pkg::event_t             ev;
	logic                         fire;
	logic [dnlc_pkg::HOLD_W-1:0]  light_hold_tick;
	logic [dnlc_pkg::HOLD_W-1:0]  button_hold_tick;
	logic                         btn_ok;
	logic                         dark_ok;
	logic                         bright_ok;
	dnlc_pkg::mode_t              mode_nxt;
	logic                         changed;
	logic [dnlc_pkg::HOLD_W-1:0]  light_hold_nxt;
	logic [dnlc_pkg::HOLD_W-1:0]  button_hold_nxt;
	logic [dnlc_pkg::OFF_W-1:0]   off_count_nxt;
	logic                         off_armed_nxt;

	// The word in the input register moves on whenever the result register is
	// free or its word is being taken in this cycle. The input register takes a
	// new word whenever it is empty or its word moves on, so a waiting result
	// does not stop the input side until both registers are full.
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// Configuration writes land directly in the registers. Every index of the
	// two-bit port names a register, so no write is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_threshold_q   <= dnlc_pkg::RST_LIGHT_THRESHOLD;
			light_hold_ticks_q  <= dnlc_pkg::RST_LIGHT_HOLD_TICKS;
			button_hold_ticks_q <= dnlc_pkg::RST_BUTTON_HOLD_TICKS;
			off_timeout_ticks_q <= dnlc_pkg::RST_OFF_TIMEOUT_TICKS;
		end else if (cfg_we) begin
			case (dnlc_pkg::reg_idx_t'(cfg_index))
				dnlc_pkg::REG_LIGHT_THRESHOLD: begin
					light_threshold_q <= cfg_data[dnlc_pkg::LEVEL_W-1:0];
				end
				dnlc_pkg::REG_LIGHT_HOLD_TICKS: begin
					light_hold_ticks_q <= cfg_data[dnlc_pkg::HOLD_W-1:0];
				end
				dnlc_pkg::REG_BUTTON_HOLD_TICKS: begin
					button_hold_ticks_q <= cfg_data[dnlc_pkg::HOLD_W-1:0];
				end
				dnlc_pkg::REG_OFF_TIMEOUT_TICKS: begin
					off_timeout_ticks_q <= cfg_data[dnlc_pkg::OFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1  <= dnlc_pkg::func_t'(func);
			level_s1 <= light_level;
		end
	end

	// Event decode. A tick first counts the hold-offs down, then the armed off
	// counter; the timeout fires when that counter would reach zero, which also
	// covers a timeout that was configured as zero.
	always_comb begin
		light_hold_tick  = light_hold_left_q;
		button_hold_tick = button_hold_left_q;
		fire             = 1'b0;
		ev               = dnlc_pkg::EV_NONE;
		case (func_s1)
			dnlc_pkg::FUNC_TICK: begin
				if (light_hold_left_q != '0) begin
					light_hold_tick = light_hold_left_q - 16'd1;
				end
				if (button_hold_left_q != '0) begin
					button_hold_tick = button_hold_left_q - 16'd1;
				end
				if (off_armed_q && (off_count_left_q <= 24'd1)) begin
					fire = 1'b1;
					ev   = dnlc_pkg::EV_TIMEOUT;
				end
			end
			dnlc_pkg::FUNC_BUTTON: begin
				ev = dnlc_pkg::EV_BUTTON;
			end
			dnlc_pkg::FUNC_SHAKE: begin
				ev = dnlc_pkg::EV_SHAKE;
			end
			default: begin
				if (level_s1[dnlc_pkg::CMP_BITS-1:0] >
				    light_threshold_q[dnlc_pkg::CMP_BITS-1:0]) begin
					ev = dnlc_pkg::EV_BRIGHT;
				end else begin
					ev = dnlc_pkg::EV_DARK;
				end
			end
		endcase
	end

	// Next mode. Button and light events count only once their hold-off has
	// run out; shake and timeout are never held off.
	assign btn_ok    = (ev == dnlc_pkg::EV_BUTTON) && (button_hold_tick == '0);
	assign dark_ok   = (ev == dnlc_pkg::EV_DARK) && (light_hold_tick == '0);
	assign bright_ok = (ev == dnlc_pkg::EV_BRIGHT) && (light_hold_tick == '0);

	always_comb begin
		mode_nxt = mode_q;
		case (mode_q)
			dnlc_pkg::MODE_DAY_OFF: begin
				if (btn_ok || ev == dnlc_pkg::EV_SHAKE) begin
					mode_nxt = dnlc_pkg::MODE_DAY_ON;
				end else if (dark_ok) begin
					mode_nxt = dnlc_pkg::MODE_NIGHT_ON;
				end
			end
			dnlc_pkg::MODE_DAY_ON: begin
				if (btn_ok) begin
					mode_nxt = dnlc_pkg::MODE_DAY_OFF;
				end else if (dark_ok) begin
					mode_nxt = dnlc_pkg::MODE_NIGHT_ON;
				end
			end
			dnlc_pkg::MODE_NIGHT_OFF: begin
				if (btn_ok || ev == dnlc_pkg::EV_SHAKE) begin
					mode_nxt = dnlc_pkg::MODE_NIGHT_ON;
				end else if (bright_ok) begin
					mode_nxt = dnlc_pkg::MODE_DAY_OFF;
				end
			end
			default: begin
				if (btn_ok || ev == dnlc_pkg::EV_TIMEOUT) begin
					mode_nxt = dnlc_pkg::MODE_NIGHT_OFF;
				end else if (bright_ok) begin
					mode_nxt = dnlc_pkg::MODE_DAY_OFF;
				end
			end
		endcase
	end

	// Counter updates. A transition restarts only the hold-off of the event
	// kind that caused it, and every entry into night-on rearms the timeout.
	always_comb begin
		changed         = (mode_nxt != mode_q);
		light_hold_nxt  = light_hold_tick;
		button_hold_nxt = button_hold_tick;
		off_count_nxt   = off_count_left_q;
		off_armed_nxt   = off_armed_q;
		if (fire) begin
			off_count_nxt = '0;
			off_armed_nxt = 1'b0;
		end else if (func_s1 == dnlc_pkg::FUNC_TICK && off_armed_q) begin
			off_count_nxt = off_count_left_q - 24'd1;
		end
		if (changed) begin
			if (mode_nxt == dnlc_pkg::MODE_NIGHT_ON) begin
				off_count_nxt = off_timeout_ticks_q;
				off_armed_nxt = 1'b1;
			end
			if (ev == dnlc_pkg::EV_BRIGHT || ev == dnlc_pkg::EV_DARK) begin
				light_hold_nxt = light_hold_ticks_q;
			end else if (ev == dnlc_pkg::EV_BUTTON) begin
				button_hold_nxt = button_hold_ticks_q;
			end
		end
	end

	// The controller state moves exactly once per word, as it leaves the input
	// register for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q             <= dnlc_pkg::MODE_DAY_OFF;
			light_hold_left_q  <= '0;
			button_hold_left_q <= '0;
			off_count_left_q   <= dnlc_pkg::RST_OFF_TIMEOUT_TICKS;
			off_armed_q        <= 1'b1;
		end else if (adv_s1) begin
			mode_q             <= mode_nxt;
			light_hold_left_q  <= light_hold_nxt;
			button_hold_left_q <= button_hold_nxt;
			off_count_left_q   <= off_count_nxt;
			off_armed_q        <= off_armed_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lamp_mode_q     <= mode_nxt;
			mode_changed_q  <= changed;
			timeout_fired_q <= fire;
		end
	end

	assign out_valid     = out_valid_q;
	assign lamp_mode     = lamp_mode_q;
	assign leds_on       = lamp_mode_q[0];
	assign mode_changed  = mode_changed_q;
	assign timeout_fired = timeout_fired_q;

endmodule

// ----- rtl/core/dnlc_checker.sv -----
// ----------------------------------------------------------------------------
// dnlc_checker: port-level checks of the day/night lamp controller
// Watches the result channel and checks mode and flag consistency over time.
// ----------------------------------------------------------------------------
module dnlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] lamp_mode,
	input logic       leds_on,
	input logic       mode_changed,
	input logic       timeout_fired
);

	// The LEDs are lit exactly in the two "on" modes.
	a_leds_match_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (leds_on == lamp_mode[0]))
		else $error("leds_on does not follow lamp_mode");

	// A timeout that changes the mode always ends in night-off.
	a_timeout_to_night_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timeout_fired && mode_changed) |->
		(lamp_mode == dnlc_pkg::MODE_NIGHT_OFF))
		else $error("timeout transition did not end in night-off");

	// A timeout in night-on always switches the lamp off, so a timeout word
	// without a change never reports night-on.
	a_timeout_not_left_on: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timeout_fired && !mode_changed) |->
		(lamp_mode != dnlc_pkg::MODE_NIGHT_ON))
		else $error("timeout left the lamp in night-on");

	// A stalled result word stays put.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(lamp_mode) && $stable(mode_changed) &&
		 $stable(timeout_fired)))
		else $error("result word changed while stalled");

endmodule

bind day_night_lamp_controller_unit dnlc_checker u_dnlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.lamp_mode     (lamp_mode),
	.leds_on       (leds_on),
	.mode_changed  (mode_changed),
	.timeout_fired (timeout_fired)
);
